/* src/bpc_pkg.sv */
// Shared constants and types for the barometric compensation pipeline.
`default_nettype none
package bpc_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_TEMP_CALIB   = 2'd0,
		CFG_PRESS_CALIB_A = 2'd1,
		CFG_PRESS_CALIB_B = 2'd2,
		CFG_PRESS_CALIB_P9 = 2'd3
	} cfg_idx_t;

	localparam int RAW_W   = 20;
	localparam int TFINE_W = 32;
	localparam int PRESS_W = 32;
	localparam int CFG_W   = 64;

	// Offset subtracted from t_fine at the head of the pressure formula.
	localparam logic signed [33:0] TFINE_OFFSET = 34'sd128000;
	// Full scale of the raw pressure reading.
	localparam logic [20:0] RAW_FULL = 21'd1048576;

	// Pipeline layout: ten front stages, one divider stage per quotient bit, seven back stages.
	localparam int DIV_BITS  = 64;
	localparam int STG_DIV0  = 10;
	localparam int STG_Q1    = STG_DIV0 + DIV_BITS + 1;
	localparam int STG_LAST  = STG_Q1 + 6;

endpackage
`default_nettype wire

/* src/baro_temp_pressure_compensation.sv */
// Top level of the pipelined barometric temperature and pressure compensation block.
//
//  Channel  | Signals                                        | Direction
//  ---------+------------------------------------------------+----------
//  input    | in_valid, in_ready, raw_temperature, raw_pressure | in
//  output   | out_valid, out_ready, temperature_fine,        | out
//           | pressure_q24_8, pressure_valid                 |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
// One item enters per cycle while the output register is not stalled; the
// pipeline holds a 64-stage restoring divider, one quotient bit per stage,
// with ten stages before it and seven after it.
// Reset clears only the valid bits and the calibration registers.
// The whole pipeline advances as one: it holds when the output register is full
// and not taken, so a stall neither drops nor repeats an item.
`default_nettype none
module baro_temp_pressure_compensation (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [19:0]           raw_temperature,
	input  wire logic [19:0]           raw_pressure,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [31:0]         temperature_fine,
	output logic [31:0]                pressure_q24_8,
	output logic                       pressure_valid,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [63:0]           cfg_data
);

	// ------------------------------------------------------------------
	// Calibration registers. T1, P1 are unsigned; the rest are signed.
	// ------------------------------------------------------------------
	logic [47:0] temp_calib_q;
	logic [63:0] press_calib_a_q;
	logic [63:0] press_calib_b_q;
	logic [15:0] press_calib_p9_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q     <= '0;
			press_calib_a_q  <= '0;
			press_calib_b_q  <= '0;
			press_calib_p9_q <= '0;
		end else if (cfg_valid) begin
			unique case (bpc_pkg::cfg_idx_t'(cfg_index))
				bpc_pkg::CFG_TEMP_CALIB:     temp_calib_q     <= cfg_data[47:0];
				bpc_pkg::CFG_PRESS_CALIB_A:  press_calib_a_q  <= cfg_data;
				bpc_pkg::CFG_PRESS_CALIB_B:  press_calib_b_q  <= cfg_data;
				bpc_pkg::CFG_PRESS_CALIB_P9: press_calib_p9_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = temp_calib_q[15:0];
	assign t2 = $signed(temp_calib_q[31:16]);
	assign t3 = $signed(temp_calib_q[47:32]);
	assign p1 = press_calib_a_q[15:0];
	assign p2 = $signed(press_calib_a_q[31:16]);
	assign p3 = $signed(press_calib_a_q[47:32]);
	assign p4 = $signed(press_calib_a_q[63:48]);
	assign p5 = $signed(press_calib_b_q[15:0]);
	assign p6 = $signed(press_calib_b_q[31:16]);
	assign p7 = $signed(press_calib_b_q[47:32]);
	assign p8 = $signed(press_calib_b_q[63:48]);
	assign p9 = $signed(press_calib_p9_q);

	// ------------------------------------------------------------------
	// Global advance. The last stage is the output register.
	// ------------------------------------------------------------------
	logic en;
	logic [bpc_pkg::STG_LAST:1] vld;

	assign en       = !vld[bpc_pkg::STG_LAST] || out_ready;
	assign in_ready = en;
	assign out_valid = vld[bpc_pkg::STG_LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[bpc_pkg::STG_LAST-1:1], in_valid};
		end
	end

	// Stage 1: the two temperature products.
	logic signed [18:0] ta_c, tb_c;
	logic signed [34:0] at2_c, at2_s1;
	logic signed [37:0] bb_c, bb_s1;
	logic [19:0]        rawp_s1, rawp_s2, rawp_s3, rawp_s4, rawp_s5, rawp_s6, rawp_s7;

	assign ta_c  = $signed({2'b00, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign tb_c  = $signed({3'b000, raw_temperature[19:4]}) - $signed({3'b000, t1});
	assign at2_c = ta_c * t2;
	assign bb_c  = tb_c * tb_c;

	// Stage 2: scale the square by T3.
	logic signed [37:0] bbsh_c;
	logic signed [53:0] bb3_c, bb3_s2;
	logic signed [34:0] v1t_s2;
	assign bbsh_c = bb_s1 >>> 12;
	assign bb3_c  = bbsh_c * t3;

	// Stage 3: t_fine. Its magnitude stays below 2^23, so the 32-bit clamp never acts.
	logic signed [53:0] bb3sh_c;
	logic signed [54:0] tsum_c;
	assign bb3sh_c = bb3_s2 >>> 14;
	assign tsum_c  = {{20{v1t_s2[34]}}, v1t_s2} + {bb3sh_c[53], bb3sh_c};

	logic [31:0] tf_s [bpc_pkg::STG_LAST:3];

	// Stage 4: v1 = t_fine - 128000 and its products.
	logic signed [33:0] v1_c;
	logic signed [67:0] sq_c;
	logic signed [49:0] v1p5_c, v1p2_c;
	logic [63:0]        sq_s4;
	logic signed [49:0] v1p5_s4, v1p2_s4, v1p5_s5, v1p2_s5, v1p5_s6, v1p2_s6;
	assign v1_c   = $signed({{2{tf_s[3][31]}}, tf_s[3]}) - bpc_pkg::TFINE_OFFSET;
	assign sq_c   = v1_c * v1_c;
	assign v1p5_c = v1_c * p5;
	assign v1p2_c = v1_c * p2;

	// Stage 5: 64x16 products of the square, split into 32-bit halves.
	logic signed [48:0] l6_c, l3_c, l6_s5, l3_s5;
	logic [31:0]        h6_c, h3_c, h6_s5, h3_s5;
	assign l6_c = $signed({1'b0, sq_s4[31:0]}) * p6;
	assign l3_c = $signed({1'b0, sq_s4[31:0]}) * p3;
	assign h6_c = sq_s4[63:32] * {{16{p6[15]}}, p6};
	assign h3_c = sq_s4[63:32] * {{16{p3[15]}}, p3};

	// Stage 6: join the halves.
	logic [63:0] sqp6_s6, sqp3_s6;

	// Stage 7: v2 and the first v1 of the pressure formula.
	logic [63:0] v2_s7, v1b_s7;
	logic [63:0] sqp3sh_c;
	assign sqp3sh_c = $signed(sqp3_s6) >>> 8;

	// Stage 8: (2^47 + v1) * P1 in halves, and the dividend before scaling.
	logic [63:0] x_c, num_s8;
	logic [47:0] xlo_c, xlo_s8;
	logic [31:0] xhi_c, xhi_s8;
	logic [20:0] pr_c;
	assign x_c   = v1b_s7 + 64'h0000_8000_0000_0000;
	assign xlo_c = x_c[31:0] * p1;
	assign xhi_c = x_c[63:32] * {16'd0, p1};
	assign pr_c  = bpc_pkg::RAW_FULL - {1'b0, rawp_s7};

	// Stage 9: divisor and the dividend times 3125 by shift and add.
	logic [63:0] prod_c, numx_c, numx_s9;
	logic [30:0] v1d_s9;
	assign prod_c = {16'd0, xlo_s8} + {xhi_s8, 32'd0};
	assign numx_c = (num_s8 << 11) + (num_s8 << 10) + (num_s8 << 5) + (num_s8 << 4)
		+ (num_s8 << 2) + num_s8;

	// Stage 10 and the divider: magnitudes, then one quotient bit per stage.
	logic [63:0] dv_num [0:bpc_pkg::DIV_BITS];
	logic [30:0] dv_rem [0:bpc_pkg::DIV_BITS];
	logic [30:0] dv_mb  [0:bpc_pkg::DIV_BITS];
	logic        dv_neg [0:bpc_pkg::DIV_BITS];
	logic [63:0] dv_num_n [1:bpc_pkg::DIV_BITS];
	logic [30:0] dv_rem_n [1:bpc_pkg::DIV_BITS];
	logic        nz_s [bpc_pkg::STG_LAST:bpc_pkg::STG_DIV0];

	always_comb begin
		logic [31:0] trial;
		logic        ge;
		for (int k = 0; k < bpc_pkg::DIV_BITS; k++) begin
			trial = {dv_rem[k], dv_num[k][63]};
			ge    = trial >= {1'b0, dv_mb[k]};
			dv_rem_n[k+1] = ge ? 31'(trial - {1'b0, dv_mb[k]}) : trial[30:0];
			dv_num_n[k+1] = {dv_num[k][62:0], ge};
		end
	end

	// Back end stages.
	logic [63:0] p_q1, p_q2, p_q3, p_q4, p_q5;
	logic [63:0] a_c;
	logic [63:0] mll_c, mll_q2;
	logic [31:0] mhl_c, mhl_q2;
	logic signed [48:0] p8lo_c, p8lo_q2;
	logic [31:0] p8hi_c, p8hi_q2;
	logic [63:0] sqa_q3, p8p_q3;
	logic signed [48:0] s9lo_c, s9lo_q4;
	logic [31:0] s9hi_c, s9hi_q4;
	logic [63:0] v2_q4, v2_q5, v1_q5, sum_q6;
	logic [63:0] sumsh_c, fp_c, s9p_c;
	logic [31:0] press_c;

	assign a_c    = $signed(p_q1) >>> 13;
	assign mll_c  = a_c[31:0] * a_c[31:0];
	assign mhl_c  = a_c[63:32] * a_c[31:0];
	assign p8lo_c = $signed({1'b0, p_q1[31:0]}) * p8;
	assign p8hi_c = p_q1[63:32] * {{16{p8[15]}}, p8};
	assign s9lo_c = $signed({1'b0, sqa_q3[31:0]}) * p9;
	assign s9hi_c = sqa_q3[63:32] * {{16{p9[15]}}, p9};
	assign s9p_c  = {{15{s9lo_q4[48]}}, s9lo_q4} + {s9hi_q4, 32'd0};
	// The shift stands alone so that it stays arithmetic.
	assign sumsh_c = $signed(sum_q6) >>> 8;
	assign fp_c   = sumsh_c + ({{48{p7[15]}}, p7} << 4);

	always_comb begin
		if (!nz_s[bpc_pkg::STG_LAST-1] || fp_c[63]) begin
			press_c = '0;
		end else if (|fp_c[62:32]) begin
			press_c = '1;
		end else begin
			press_c = fp_c[31:0];
		end
	end

	// Payload registers, no reset.
	always_ff @(posedge clk) begin
		if (en) begin
			at2_s1  <= at2_c;
			bb_s1   <= bb_c;
			rawp_s1 <= raw_pressure;

			v1t_s2  <= at2_s1 >>> 11;
			bb3_s2  <= bb3_c;
			rawp_s2 <= rawp_s1;

			tf_s[3] <= tsum_c[31:0];
			for (int k = 4; k <= bpc_pkg::STG_LAST; k++) begin
				tf_s[k] <= tf_s[k-1];
			end
			rawp_s3 <= rawp_s2;

			sq_s4   <= sq_c[63:0];
			v1p5_s4 <= v1p5_c;
			v1p2_s4 <= v1p2_c;
			rawp_s4 <= rawp_s3;

			l6_s5   <= l6_c;
			l3_s5   <= l3_c;
			h6_s5   <= h6_c;
			h3_s5   <= h3_c;
			v1p5_s5 <= v1p5_s4;
			v1p2_s5 <= v1p2_s4;
			rawp_s5 <= rawp_s4;

			sqp6_s6 <= {{15{l6_s5[48]}}, l6_s5} + {h6_s5, 32'd0};
			sqp3_s6 <= {{15{l3_s5[48]}}, l3_s5} + {h3_s5, 32'd0};
			v1p5_s6 <= v1p5_s5;
			v1p2_s6 <= v1p2_s5;
			rawp_s6 <= rawp_s5;

			v2_s7   <= sqp6_s6 + ({{14{v1p5_s6[49]}}, v1p5_s6} << 17)
				+ ({{48{p4[15]}}, p4} << 35);
			v1b_s7  <= sqp3sh_c + ({{14{v1p2_s6[49]}}, v1p2_s6} << 12);
			rawp_s7 <= rawp_s6;

			xlo_s8  <= xlo_c;
			xhi_s8  <= xhi_c;
			num_s8  <= ({43'd0, pr_c} << 31) - v2_s7;

			v1d_s9  <= prod_c[63:33];
			numx_s9 <= numx_c;

			// Stage 10 loads divider slot 0.
			dv_mb[0]  <= v1d_s9[30] ? 31'(-v1d_s9) : v1d_s9;
			dv_num[0] <= numx_s9[63] ? -numx_s9 : numx_s9;
			dv_rem[0] <= '0;
			dv_neg[0] <= numx_s9[63] ^ v1d_s9[30];
			nz_s[bpc_pkg::STG_DIV0] <= |v1d_s9;
			for (int k = bpc_pkg::STG_DIV0 + 1; k <= bpc_pkg::STG_LAST; k++) begin
				nz_s[k] <= nz_s[k-1];
			end
			for (int k = 1; k <= bpc_pkg::DIV_BITS; k++) begin
				dv_num[k] <= dv_num_n[k];
				dv_rem[k] <= dv_rem_n[k];
				dv_mb[k]  <= dv_mb[k-1];
				dv_neg[k] <= dv_neg[k-1];
			end

			p_q1    <= dv_neg[bpc_pkg::DIV_BITS] ? -dv_num[bpc_pkg::DIV_BITS]
				: dv_num[bpc_pkg::DIV_BITS];

			mll_q2  <= mll_c;
			mhl_q2  <= mhl_c;
			p8lo_q2 <= p8lo_c;
			p8hi_q2 <= p8hi_c;
			p_q2    <= p_q1;

			sqa_q3  <= mll_q2 + {mhl_q2[30:0], 33'd0};
			p8p_q3  <= {{15{p8lo_q2[48]}}, p8lo_q2} + {p8hi_q2, 32'd0};
			p_q3    <= p_q2;

			s9lo_q4 <= s9lo_c;
			s9hi_q4 <= s9hi_c;
			v2_q4   <= $signed(p8p_q3) >>> 19;
			p_q4    <= p_q3;

			v1_q5   <= $signed(s9p_c) >>> 25;
			v2_q5   <= v2_q4;
			p_q5    <= p_q4;

			sum_q6  <= p_q5 + v1_q5 + v2_q5;

			pressure_q24_8 <= press_c;
			pressure_valid <= nz_s[bpc_pkg::STG_LAST-1];
		end
	end

	assign temperature_fine = $signed(tf_s[bpc_pkg::STG_LAST]);

`ifndef SYNTH
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pressure_valid |-> pressure_q24_8 == '0)
		else $error("pressure not zero with zero divisor");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld[bpc_pkg::STG_DIV0 + bpc_pkg::DIV_BITS] && dv_mb[bpc_pkg::DIV_BITS] != '0
		|-> dv_rem[bpc_pkg::DIV_BITS] < dv_mb[bpc_pkg::DIV_BITS])
		else $error("divider remainder not below divisor");

	a_tfine_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_fine < 32'sd268435456
		&& temperature_fine > -32'sd268435456)
		else $error("t_fine outside reachable range");
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench for the barometric temperature and pressure compensation pipeline.
`default_nettype none
module tb;

	// A raw reading pair as it enters the block.
	typedef struct packed {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
	} reading_t;

	// One compensated result as it leaves the block.
	typedef struct packed {
		logic signed [31:0] tfine;
		logic [31:0]        press;
		logic               pvalid;
	} comp_t;

	localparam int LATENCY  = bpc_pkg::STG_LAST + 10;
	localparam int WD_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	logic        out_valid;
	logic        out_ready;
	logic signed [31:0] temperature_fine;
	logic [31:0] pressure_q24_8;
	logic        pressure_valid;
	logic        cfg_valid;
	logic        cfg_ready;
	bpc_pkg::cfg_idx_t cfg_index;
	logic [63:0] cfg_data;

	baro_temp_pressure_compensation i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.out_valid(out_valid), .out_ready(out_ready),
		.temperature_fine(temperature_fine), .pressure_q24_8(pressure_q24_8),
		.pressure_valid(pressure_valid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Calibration shadow kept by the predictor.
	logic [47:0] cal_temp;
	logic [63:0] cal_pa;
	logic [63:0] cal_pb;
	logic [15:0] cal_p9;

	reading_t pending_readings[$];
	comp_t    expected_results[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	int  errors;
	int  n_sent;
	int  n_checked;
	int  n_invalid;
	int  quiet_cycles;

	// Compensation predictor: the 64-bit integer formula, all intermediates
	// wrapping at 64 bits with arithmetic right shifts.
	function automatic comp_t compensate(reading_t r);
		logic signed [63:0] t1, t2, t3, a, b, v1, v2, tf;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p, num;
		logic [63:0] ma, mb, q;
		comp_t res;
		t1 = {48'd0, cal_temp[15:0]};
		t2 = {{48{cal_temp[31]}}, cal_temp[31:16]};
		t3 = {{48{cal_temp[47]}}, cal_temp[47:32]};
		a  = $signed({44'd0, r.raw_t}) >>> 3;
		a  = a - (t1 <<< 1);
		b  = ($signed({44'd0, r.raw_t}) >>> 4) - t1;
		v1 = (a * t2) >>> 11;
		v2 = (((b * b) >>> 12) * t3) >>> 14;
		tf = v1 + v2;
		// The fine temperature saturates to 32 bits before feeding pressure.
		if (tf < -64'sd2147483648)
			tf = -64'sd2147483648;
		else if (tf > 64'sd2147483647)
			tf = 64'sd2147483647;
		res.tfine = tf[31:0];

		p1 = {48'd0, cal_pa[15:0]};
		p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
		p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
		p4 = {{48{cal_pa[63]}}, cal_pa[63:48]};
		p5 = {{48{cal_pb[15]}}, cal_pb[15:0]};
		p6 = {{48{cal_pb[31]}}, cal_pb[31:16]};
		p7 = {{48{cal_pb[47]}}, cal_pb[47:32]};
		p8 = {{48{cal_pb[63]}}, cal_pb[63:48]};
		p9 = {{48{cal_p9[15]}}, cal_p9};

		v1 = tf - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;

		if (v1 == 0) begin
			// A zero divisor forces pressure to zero and flags it.
			res.press  = '0;
			res.pvalid = 1'b0;
		end else begin
			p   = 64'sd1048576 - $signed({44'd0, r.raw_p});
			num = ((p <<< 31) - v2) * 64'sd3125;
			// Signed division truncating toward zero, done on magnitudes so
			// the most negative dividend wraps the way the hardware does.
			ma  = num[63] ? -num : num;
			mb  = v1[63] ? -v1 : v1;
			q   = ma / mb;
			if (num[63] != v1[63])
				q = -q;
			p   = $signed(q);
			v1  = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			v2  = (p8 * p) >>> 19;
			p   = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
			if (p < 0)
				res.press = '0;
			else if (p > 64'sd4294967295)
				res.press = '1;
			else
				res.press = p[31:0];
			res.pvalid = 1'b1;
		end
		return res;
	endfunction

	always #4 clk = ~clk;

	// Driver: presents the oldest pending item, idling at random between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid        <= 1'b0;
			raw_temperature <= '0;
			raw_pressure    <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(compensate({raw_temperature, raw_pressure}));
				n_sent++;
			end
			if ((!in_valid || in_ready) && pending_readings.size() > 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				in_valid        <= 1'b1;
				raw_temperature <= pending_readings[0].raw_t;
				raw_pressure    <= pending_readings[0].raw_p;
				void'(pending_readings.pop_front());
			end else if (in_valid && in_ready) begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each accepted result against the oldest expectation
	// and throttles out_ready at random.
	always @(posedge clk or negedge arst_n) begin
		comp_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result tfine=%0d press=%0h valid=%0b",
						$time, temperature_fine, pressure_q24_8, pressure_valid);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					n_checked++;
					if (!exp_r.pvalid)
						n_invalid++;
					if (temperature_fine !== exp_r.tfine) begin
						$display("%0t: temperature_fine expected %0d actual %0d",
							$time, exp_r.tfine, temperature_fine);
						errors++;
					end
					if (pressure_q24_8 !== exp_r.press) begin
						$display("%0t: pressure_q24_8 expected %0h actual %0h",
							$time, exp_r.press, pressure_q24_8);
						errors++;
					end
					if (pressure_valid !== exp_r.pvalid) begin
						$display("%0t: pressure_valid expected %0b actual %0b",
							$time, exp_r.pvalid, pressure_valid);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: ends the run if no handshake happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WD_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Writes one calibration register while the pipeline is idle.
	task automatic write_cal(bpc_pkg::cfg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			bpc_pkg::CFG_TEMP_CALIB:    cal_temp = val[47:0];
			bpc_pkg::CFG_PRESS_CALIB_A: cal_pa = val;
			bpc_pkg::CFG_PRESS_CALIB_B: cal_pb = val;
			bpc_pkg::CFG_PRESS_CALIB_P9: cal_p9 = val[15:0];
		endcase
	endtask

	task automatic write_all(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
			logic [15:0] p9);
		write_cal(bpc_pkg::CFG_TEMP_CALIB, {16'd0, tc});
		write_cal(bpc_pkg::CFG_PRESS_CALIB_A, pa);
		write_cal(bpc_pkg::CFG_PRESS_CALIB_B, pb);
		write_cal(bpc_pkg::CFG_PRESS_CALIB_P9, {48'd0, p9});
	endtask

	// Waits for all queued items to drain, then lets the pipeline settle.
	task automatic drain();
		while (pending_readings.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [19:0] rand_raw(int mode);
		case (mode)
			0: return 20'(($urandom_range(1) != 0) ? 20'hFFFFF : 20'h0);
			1: return 20'($urandom);
			default: return 20'($urandom_range(600000, 300000));
		endcase
	endfunction

	task automatic queue_random(int count);
		reading_t r;
		for (int i = 0; i < count; i++) begin
			r.raw_t = rand_raw(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2));
			r.raw_p = rand_raw(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2));
			pending_readings.push_back(r);
		end
	endtask

	// Typical factory calibration, taken as a realistic operating point.
	localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
	localparam logic [63:0] TYP_PA = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
	localparam logic [63:0] TYP_PB = {-16'sd12000, 16'd15500, -16'sd7, 16'd140};
	localparam logic [15:0] TYP_P9 = 16'd6000;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_temperature = '0;
		raw_pressure = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = bpc_pkg::CFG_TEMP_CALIB;
		cfg_data = '0;
		cal_temp = '0;
		cal_pa = '0;
		cal_pb = '0;
		cal_p9 = '0;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_invalid = 0;
		quiet_cycles = 0;
		send_idle_pct = 38;
		recv_idle_pct = 54;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// All-zero calibration after reset: the divisor is zero, so every
		// pressure comes back flagged invalid.
		pending_readings.push_back({20'h0, 20'h0});
		pending_readings.push_back({20'hFFFFF, 20'hFFFFF});
		drain();

		// Directed: typical calibration with extreme and mid-scale readings.
		write_all(TYP_T, TYP_PA, TYP_PB, TYP_P9);
		pending_readings.push_back({20'h0, 20'h0});
		pending_readings.push_back({20'hFFFFF, 20'hFFFFF});
		pending_readings.push_back({20'h0, 20'hFFFFF});
		pending_readings.push_back({20'hFFFFF, 20'h0});
		pending_readings.push_back({20'd519888, 20'd415148});
		pending_readings.push_back({20'h55555, 20'hAAAAA});
		pending_readings.push_back({20'hAAAAA, 20'h55555});
		drain();

		// Directed: extreme coefficients drive pressure into saturation on both sides.
		write_all({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
			{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
		pending_readings.push_back({20'hFFFFF, 20'h0});
		pending_readings.push_back({20'h0, 20'hFFFFF});
		pending_readings.push_back({20'h0, 20'h0});
		drain();
		write_all({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
			{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
		pending_readings.push_back({20'hFFFFF, 20'hFFFFF});
		pending_readings.push_back({20'h0, 20'h0});
		pending_readings.push_back({20'h80000, 20'h12345});
		drain();

		// Random phases: realistic calibration mostly, fully random now and then.
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				send_idle_pct = 54;
				recv_idle_pct = 38;
			end else if (ph == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph % 3 == 2)
				write_all(48'(rand64()), rand64(), rand64(), 16'($urandom));
			else
				write_all(TYP_T ^ 48'(rand64() & 64'h000F_00FF_00FF),
					TYP_PA ^ (rand64() & 64'h00FF_00FF_00FF_03FF),
					TYP_PB ^ (rand64() & 64'h00FF_00FF_00FF_000F), TYP_P9 ^ 16'($urandom_range(255)));
			queue_random(125);
			drain();
		end

		$display("tb: %0d items sent, %0d results checked, %0d with zero divisor",
			n_sent, n_checked, n_invalid);
		$display("tb: covered extreme readings, saturating coefficients and three idling mixes");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
